// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/bhpq_pkg.sv -----
`default_nettype none

package bhpq_pkg;

   localparam int KEY_W = 32;
   localparam int TAG_W = 16;
   localparam int ENTRY_W = KEY_W + TAG_W;
   localparam int STATUS_W = 2;
   localparam int OCC_W = 6;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic signed [KEY_W-1:0] out_key;
      logic [TAG_W-1:0] out_tag;
      logic [OCC_W-1:0] occupancy;
   } result_type;

endpackage

`default_nettype wire

// ----- src/bhpq_if.sv -----
`default_nettype none

interface bhpq_req_if
   import bhpq_pkg::*;
   ;
   logic valid;
   logic ready;
   logic func;
   logic signed [KEY_W-1:0] key;
   logic [TAG_W-1:0] tag;

   modport source (output valid, output func, output key, output tag, input ready);
   modport sink (input valid, input func, input key, input tag, output ready);
endinterface

interface bhpq_rsp_if
   import bhpq_pkg::*;
   ;
   logic valid;
   logic ready;
   logic [STATUS_W-1:0] status;
   logic signed [KEY_W-1:0] out_key;
   logic [TAG_W-1:0] out_tag;
   logic [OCC_W-1:0] occupancy;

   modport source (output valid, output status, output out_key, output out_tag,
                   output occupancy, input ready);
   modport sink (input valid, input status, input out_key, input out_tag,
                 input occupancy, output ready);
endinterface

`default_nettype wire

// ----- src/binary_max_heap_priority_queue.sv -----
// Priority queue of signed 32-bit keys with 16-bit tags, kept as a max-heap in one
// dual-read-port memory of CAPACITY+1 entries.
// The req_ch channel takes one request: func 0 inserts {key, tag}, func 1 removes
// the entry with the largest key. Each request yields exactly one response on
// rsp_ch with a status, the removed key and tag (zero otherwise) and the count
// of entries held afterwards, modulo 64.
// The block works on one request at a time. A request walks the heap one level
// at a time, with one memory read step and one compare step per level. A full
// insert or an empty remove goes straight to its response without touching the
// memory. Once a response moves into the output register, the controller returns
// to idle and takes the next request.
// The response sits in an output register, so the next request is accepted while
// a finished response still waits; if the receiver stalls longer, the block holds
// the following response in its controller and takes no new request meanwhile.
// Reset empties the queue at once; memory contents are not cleared, since only
// entries written since the last reset are ever used.
`default_nettype none

module binary_max_heap_priority_queue
   import bhpq_pkg::*;
#(
   parameter int CAPACITY = 63
) (
   input wire logic clock,
   input wire logic reset,
   bhpq_req_if.sink req_ch,
   bhpq_rsp_if.source rsp_ch
);

`include "assert_macros.svh"

   localparam int DEPTH = CAPACITY + 1;
   localparam int AW = $clog2(CAPACITY + 1);

   logic res_valid;
   logic res_ready;
   result_type res;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [AW-1:0] rd_addr_a;
   logic [AW-1:0] rd_addr_b;
   logic [ENTRY_W-1:0] rd_data_a;
   logic [ENTRY_W-1:0] rd_data_b;

   logic rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   bhpq_ctrl #(
      .CAPACITY(CAPACITY),
      .AW(AW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res(res),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   bhpq_mem #(
      .DEPTH(DEPTH),
      .AW(AW)
   ) u_mem (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_data_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_data_ff.status;
   assign rsp_ch.out_key = rsp_data_ff.out_key;
   assign rsp_ch.out_tag = rsp_data_ff.out_tag;
   assign rsp_ch.occupancy = rsp_data_ff.occupancy;

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "Request accepted while another was in progress.")
   `ASSERT_NEXT(a_result_captured, clock, reset, res_valid && res_ready, rsp_valid_ff, "Finished response was not captured in the output register.")
   `ASSERT_SAME(a_no_data_unless_ok, clock, reset, res_valid && res.status != ST_OK, res.out_key == '0 && res.out_tag == '0, "Failed request carries a nonzero key or tag.")

endmodule

`default_nettype wire

// ----- src/bhpq_mem.sv -----
`default_nettype none

module bhpq_mem
   import bhpq_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW = 6
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [AW-1:0] wr_addr,
   input wire logic [ENTRY_W-1:0] wr_data,
   input wire logic [AW-1:0] rd_addr_a,
   input wire logic [AW-1:0] rd_addr_b,
   output logic [ENTRY_W-1:0] rd_data_a,
   output logic [ENTRY_W-1:0] rd_data_b
);

   logic [ENTRY_W-1:0] store [DEPTH];
   logic [ENTRY_W-1:0] rd_data_a_ff;
   logic [ENTRY_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= store[rd_addr_a];
      rd_data_b_ff <= store[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// ----- src/bhpq_ctrl.sv -----
`default_nettype none

module bhpq_ctrl
   import bhpq_pkg::*;
#(
   parameter int CAPACITY = 63,
   parameter int AW = 6
) (
   input wire logic clock,
   input wire logic reset,
   bhpq_req_if.sink req_ch,
   output logic res_valid,
   input wire logic res_ready,
   output result_type res,
   output logic wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [ENTRY_W-1:0] wr_data,
   output logic [AW-1:0] rd_addr_a,
   output logic [AW-1:0] rd_addr_b,
   input wire logic [ENTRY_W-1:0] rd_data_a,
   input wire logic [ENTRY_W-1:0] rd_data_b
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UP_RD = 3'd1;
   localparam logic [2:0] S_UP_CMP = 3'd2;
   localparam logic [2:0] S_DN_LOAD = 3'd3;
   localparam logic [2:0] S_DN_RD = 3'd4;
   localparam logic [2:0] S_DN_CMP = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW:0] child_ff, child_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic signed [KEY_W-1:0] res_key_ff, res_key_in;
   logic [TAG_W-1:0] res_tag_ff, res_tag_in;

   logic [AW:0] child_plus;
   logic signed [KEY_W-1:0] key_a, key_b, sel_key;
   logic take_b;
   logic [AW-1:0] sel_idx;
   logic [ENTRY_W-1:0] sel_data;

   assign child_plus = child_ff + (AW+1)'(1);
   assign key_a = $signed(rd_data_a[ENTRY_W-1:TAG_W]);
   assign key_b = $signed(rd_data_b[ENTRY_W-1:TAG_W]);
   assign take_b = (child_ff[AW-1:0] < count_ff) && (key_a < key_b);
   assign sel_key = take_b ? key_b : key_a;
   assign sel_idx = take_b ? child_plus[AW-1:0] : child_ff[AW-1:0];
   assign sel_data = take_b ? rd_data_b : rd_data_a;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res.status = status_ff;
   assign res.out_key = res_key_ff;
   assign res.out_tag = res_tag_ff;
   assign res.occupancy = OCC_W'(count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      child_in = child_ff;
      key_in = key_ff;
      tag_in = tag_ff;
      status_in = status_ff;
      res_key_in = res_key_ff;
      res_tag_in = res_tag_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = {key_ff, tag_ff};
      rd_addr_a = AW'(1);
      rd_addr_b = count_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               status_in = ST_OK;
               res_key_in = '0;
               res_tag_in = '0;
               key_in = req_ch.key;
               tag_in = req_ch.tag;
               if (req_ch.func == FUNC_INSERT) begin
                  if (count_ff >= AW'(CAPACITY)) begin
                     status_in = ST_FULL;
                     state_in = S_DONE;
                  end else begin
                     idx_in = count_ff + AW'(1);
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in = S_DONE;
                  end else begin
                     count_in = count_ff - AW'(1);
                     state_in = S_DN_LOAD;
                  end
               end
            end
         end
         S_UP_RD: begin
            rd_addr_a = idx_ff >> 1;
            if (idx_ff == AW'(1)) begin
               wr_en = 1'b1;
               count_in = count_ff + AW'(1);
               state_in = S_DONE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (key_ff > key_a) begin
               wr_data = rd_data_a;
               idx_in = idx_ff >> 1;
               state_in = S_UP_RD;
            end else begin
               count_in = count_ff + AW'(1);
               state_in = S_DONE;
            end
         end
         S_DN_LOAD: begin
            res_key_in = key_a;
            res_tag_in = rd_data_a[TAG_W-1:0];
            key_in = key_b;
            tag_in = rd_data_b[TAG_W-1:0];
            idx_in = AW'(1);
            child_in = (AW+1)'(2);
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            rd_addr_a = child_ff[AW-1:0];
            rd_addr_b = child_plus[AW-1:0];
            if (child_ff > {1'b0, count_ff}) begin
               wr_en = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (key_ff >= sel_key) begin
               state_in = S_DONE;
            end else begin
               wr_data = sel_data;
               idx_in = sel_idx;
               child_in = {sel_idx, 1'b0};
               state_in = S_DN_RD;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      child_ff <= child_in;
      key_ff <= key_in;
      tag_ff <= tag_in;
      status_ff <= status_in;
      res_key_ff <= res_key_in;
      res_tag_ff <= res_tag_in;
   end

endmodule

`default_nettype wire

// ----- tb/binary_max_heap_priority_queue_tb.sv -----
`timescale 1ns / 1ps

module binary_max_heap_priority_queue_tb;
   import bhpq_pkg::*;

   localparam int HEAP_CAPACITY = 63;
   localparam int RANDOM_TARGET = 1880;
   localparam int TAIL_START = 1730;
   localparam int LONG_HOLD = 400;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_REPORTS = 25;

   localparam int EP_FILL = 0;
   localparam int EP_DRAIN = 1;
   localparam int EP_LAST = 4;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } heap_entry_t;

   class heap_scoreboard;
      heap_entry_t slots[HEAP_CAPACITY+1];
      int unsigned held;
      int unsigned peak;
      result_type pending_responses[$];
      int unsigned mismatches;
      int unsigned inserts;
      int unsigned removes;
      int unsigned full_drops;
      int unsigned empty_removes;
      int unsigned checked;

      function new();
         held = 0;
         peak = 0;
         mismatches = 0;
         inserts = 0;
         removes = 0;
         full_drops = 0;
         empty_removes = 0;
         checked = 0;
      endfunction

      // Applies one accepted request to the local heap and queues the response it must give.
      function void note_request(logic func, logic signed [KEY_W-1:0] key,
                                 logic [TAG_W-1:0] tag);
         result_type r;
         int unsigned slot;
         int unsigned child;
         heap_entry_t moving;
         r = '0;
         if (func == FUNC_INSERT) begin
            inserts++;
            if (held >= HEAP_CAPACITY) begin
               r.status = ST_FULL;
               full_drops++;
            end else begin
               slot = held + 1;
               while (slot != 1 && $signed(key) > $signed(slots[slot/2].key)) begin
                  slots[slot] = slots[slot/2];
                  slot = slot / 2;
               end
               slots[slot].key = key;
               slots[slot].tag = tag;
               held++;
               if (held > peak) peak = held;
            end
         end else begin
            removes++;
            if (held == 0) begin
               r.status = ST_EMPTY;
               empty_removes++;
            end else begin
               r.status = ST_OK;
               r.out_key = slots[1].key;
               r.out_tag = slots[1].tag;
               moving = slots[held];
               held--;
               slot = 1;
               child = 2;
               while (child <= held) begin
                  if (child < held &&
                      $signed(slots[child].key) < $signed(slots[child+1].key)) child++;
                  if ($signed(moving.key) >= $signed(slots[child].key)) break;
                  slots[slot] = slots[child];
                  slot = child;
                  child = child * 2;
               end
               slots[slot] = moving;
            end
         end
         r.occupancy = held[OCC_W-1:0];
         pending_responses.push_back(r);
      endfunction

      function void compare_field(string name, longint expected, longint actual);
         if (expected != actual) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected,
                        actual);
         end
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response with no request outstanding, expected none, got %h",
                        $time, got);
         end else begin
            want = pending_responses.pop_front();
            checked++;
            compare_field("status", want.status, got.status);
            compare_field("out_key", $signed(want.out_key), $signed(got.out_key));
            compare_field("out_tag", want.out_tag, got.out_tag);
            compare_field("occupancy", want.occupancy, got.occupancy);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bhpq_req_if req_bus();
   bhpq_rsp_if rsp_bus();

   heap_scoreboard sb;
   int unsigned items_sent;
   int unsigned idle_pct;
   bit quiet_tail;
   bit hold_request;
   int unsigned cycle_count;

   binary_max_heap_priority_queue #(
      .CAPACITY(HEAP_CAPACITY)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   function automatic logic signed [KEY_W-1:0] random_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom;
         5, 6, 7: return int'($urandom_range(0, 8)) - 4;
         8: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fffffff;
               1: return 32'sh80000000;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000) ^
                         $urandom_range(0, 15);
      endcase
   endfunction

   task automatic send_request(input logic func, input logic signed [KEY_W-1:0] key,
                               input logic [TAG_W-1:0] tag);
      if (items_sent >= TAIL_START) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(1, 100) <= idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= func;
      req_bus.key <= key;
      req_bus.tag <= tag;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(func, key, tag);
      items_sent++;
   endtask

   initial begin
      int unsigned stall_left;
      int unsigned stall_pct;
      bit hold_taken;
      result_type got;
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
      stall_pct = 10;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.status = rsp_bus.status;
            got.out_key = rsp_bus.out_key;
            got.out_tag = rsp_bus.out_tag;
            got.occupancy = rsp_bus.occupancy;
            sb.check_response(got);
         end
         if (cycle_count % 200 == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 8;
               default: stall_pct = 30;
            endcase
         end
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && !quiet_tail && $urandom_range(1, 100) <= stall_pct) begin
            stall_left = $urandom_range(1, 16);
         end
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned episode;
      int unsigned episodes_done;
      int unsigned extra;
      int unsigned run_length;
      int unsigned insert_pct;
      sb = new();
      items_sent = 0;
      idle_pct = 10;
      quiet_tail = 1'b0;
      hold_request = 1'b0;
      episodes_done = 0;
      req_bus.valid <= 1'b0;
      req_bus.func <= FUNC_INSERT;
      req_bus.key <= '0;
      req_bus.tag <= '0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty removes, extreme keys and tags, then equal keys whose tags reveal the tie order.
      send_request(FUNC_REMOVE, 0, 0);
      send_request(FUNC_REMOVE, 32'shffffffff, 16'hffff);
      send_request(FUNC_INSERT, 0, 16'h0000);
      send_request(FUNC_INSERT, 32'sh7fffffff, 16'hffff);
      send_request(FUNC_INSERT, 32'sh80000000, 16'h1234);
      send_request(FUNC_INSERT, -1, 16'h0005);
      send_request(FUNC_INSERT, 5, 16'h000a);
      send_request(FUNC_INSERT, 5, 16'h000b);
      send_request(FUNC_INSERT, 5, 16'h000c);
      send_request(FUNC_INSERT, 32'sh7fffffff, 16'h0002);
      send_request(FUNC_INSERT, 5, 16'h000d);
      repeat (12) send_request(FUNC_REMOVE, random_key(), TAG_W'($urandom_range(0, 65535)));

      while (items_sent < RANDOM_TARGET) begin
         episode = (episodes_done < 2) ? episodes_done : $urandom_range(EP_FILL, EP_LAST);
         if (episodes_done == 0) hold_request = 1'b1;
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 10;
            default: idle_pct = 35;
         endcase
         case (episode)
            EP_FILL: begin
               extra = $urandom_range(1, 4);
               while (extra != 0) begin
                  if (sb.held >= HEAP_CAPACITY) extra--;
                  send_request(FUNC_INSERT, random_key(), TAG_W'($urandom_range(0, 65535)));
               end
            end
            EP_DRAIN: begin
               extra = $urandom_range(1, 3);
               while (extra != 0) begin
                  if (sb.held == 0) extra--;
                  send_request(FUNC_REMOVE, random_key(), TAG_W'($urandom_range(0, 65535)));
               end
            end
            default: begin
               run_length = $urandom_range(30, 120);
               insert_pct = $urandom_range(30, 70);
               repeat (run_length)
                  send_request(($urandom_range(1, 100) <= insert_pct) ? FUNC_INSERT : FUNC_REMOVE,
                               random_key(), TAG_W'($urandom_range(0, 65535)));
            end
         endcase
         episodes_done++;
      end

      req_bus.valid <= 1'b0;
      while (sb.pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests: %0d inserts (%0d refused as full), %0d removes (%0d on empty).",
               items_sent, sb.inserts, sb.full_drops, sb.removes, sb.empty_removes);
      $display("Checked %0d responses over %0d episodes; occupancy peaked at %0d of %0d.",
               sb.checked, episodes_done, sb.peak, HEAP_CAPACITY);
      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
